// File: hw/rtl/cdc_pkg.sv
// Shared types and constants for the calendar date counter.
package cdc_pkg;

	localparam logic [11:0] YEAR_MIN = 12'd1800;
	localparam logic [11:0] YEAR_MAX = 12'd2099;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP,
		ST_SUM,
		ST_WDAY,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic sum;
		logic wday;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic func;
		logic count_zero;
		logic at_end;
	} status_t;

endpackage

// File: hw/rtl/cdc_ctrl.sv
// Controller state machine for the calendar date counter.
module cdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cdc_pkg::status_t  status,
	output cdc_pkg::cmd_t     cmd
);
	import cdc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_STEP;
				end
			end
			ST_STEP: begin
				// captured func decides: load items pass straight through
				if (!status.func) begin
					cmd.load = 1'b1;
					state_d  = ST_SUM;
				end else begin
					cmd.step = 1'b1;
					if (status.count_zero || status.at_end) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_WDAY;
			end
			ST_WDAY: begin
				cmd.wday = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/cdc_dpath.sv
// Datapath for the calendar date counter: date registers, stepper, weekday.
module cdc_dpath #(
	parameter int DELTA_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cdc_pkg::cmd_t                cmd,
	output cdc_pkg::status_t             status,
	input  logic                         func,
	input  logic [4:0]                   load_day,
	input  logic [3:0]                   load_month,
	input  logic [11:0]                  load_year,
	input  logic signed [DELTA_BITS-1:0] day_delta,
	output logic [4:0]                   cur_day,
	output logic [3:0]                   cur_month,
	output logic [11:0]                  cur_year,
	output logic [2:0]                   week_day,
	output logic                         range_hit
);
	import cdc_pkg::*;

	localparam logic [15:0] RECIP_7 = 16'd37450; // ceil(2^18 / 7)

	// valid only for years 1800..2099
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'd0) && (y != 12'd1800) && (y != 12'd1900);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	// floor(31 * mm / 12) for the March-based month index
	function automatic logic [4:0] month_ofs(input logic [3:0] mm);
		logic [4:0] v;
		unique case (mm)
			4'd1:    v = 5'd2;
			4'd2:    v = 5'd5;
			4'd3:    v = 5'd7;
			4'd4:    v = 5'd10;
			4'd5:    v = 5'd12;
			4'd6:    v = 5'd15;
			4'd7:    v = 5'd18;
			4'd8:    v = 5'd20;
			4'd9:    v = 5'd23;
			4'd10:   v = 5'd25;
			4'd11:   v = 5'd28;
			default: v = 5'd31;
		endcase
		return v;
	endfunction

	logic [4:0]            day_q;
	logic [3:0]            month_q;
	logic [11:0]           year_q;
	logic                  func_q;
	logic [4:0]            ld_day_q;
	logic [3:0]            ld_month_q;
	logic [11:0]           ld_year_q;
	logic [DELTA_BITS-1:0] count_q;
	logic                  neg_q;
	logic                  hit_q;
	logic [11:0]           sum_q;
	logic [2:0]            wday_q;
	logic [4:0]            out_day_q;
	logic [3:0]            out_month_q;
	logic [11:0]           out_year_q;
	logic [2:0]            out_wday_q;
	logic                  out_hit_q;

	// magnitude of the delta; the most negative value fits as unsigned
	logic [DELTA_BITS-1:0] delta_mag;
	assign delta_mag = day_delta[DELTA_BITS-1] ? (~day_delta + 1'b1) : day_delta;

	// load repair
	logic [11:0] yr_a, yr_c;
	logic [3:0]  mo_c;
	logic [4:0]  len_ld, dy_c;

	always_comb begin
		yr_a = ld_year_q;
		if (ld_year_q < 12'd100) begin
			yr_a = ld_year_q + ((ld_year_q < 12'd50) ? 12'd2000 : 12'd1900);
		end
		yr_c = yr_a;
		if (yr_a < YEAR_MIN) yr_c = YEAR_MIN;
		if (yr_a > YEAR_MAX) yr_c = YEAR_MAX;
		mo_c = ld_month_q;
		if (ld_month_q < 4'd1)  mo_c = 4'd1;
		if (ld_month_q > 4'd12) mo_c = 4'd12;
		len_ld = month_len(mo_c, is_leap(yr_c));
		dy_c = ld_day_q;
		if (ld_day_q < 5'd1)  dy_c = 5'd1;
		if (ld_day_q > len_ld) dy_c = len_ld;
	end

	// one-day step
	logic [4:0]  len_cur, len_prev;
	logic        at_end, count_zero, do_step;

	assign len_cur    = month_len(month_q, is_leap(year_q));
	assign len_prev   = month_len(month_q - 4'd1, is_leap(year_q));
	assign count_zero = (count_q == '0);
	assign at_end     = neg_q ?
		((year_q <= YEAR_MIN) && (month_q <= 4'd1) && (day_q <= 5'd1)) :
		((year_q >= YEAR_MAX) && (month_q >= 4'd12) && (day_q >= 5'd31));
	assign do_step    = cmd.step && !count_zero && !at_end;

	// weekday terms, March-based year
	logic        early;
	logic [11:0] yy, c100, c400, sum_d;
	logic [3:0]  mm;

	always_comb begin
		early = (month_q <= 4'd2);
		yy    = year_q - {11'd0, early};
		mm    = early ? (month_q + 4'd10) : (month_q - 4'd2);
		if (yy < 12'd1800)      c100 = 12'd17;
		else if (yy < 12'd1900) c100 = 12'd18;
		else if (yy < 12'd2000) c100 = 12'd19;
		else                    c100 = 12'd20;
		c400  = (yy < 12'd2000) ? 12'd4 : 12'd5;
		sum_d = {7'd0, day_q} + yy + {2'd0, yy[11:2]} - c100 + c400
			+ {7'd0, month_ofs(mm)};
	end

	// sum mod 7 through a reciprocal; exact for sums below 4096
	logic [27:0] prod;
	logic [9:0]  quo;
	logic [12:0] quo7, rem;

	assign prod = sum_q * RECIP_7;
	assign quo  = prod[27:18];
	assign quo7 = {quo, 3'd0} - {3'd0, quo};
	assign rem  = {1'b0, sum_q} - quo7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= 5'd1;
			month_q <= 4'd1;
			year_q  <= 12'd2000;
		end else if (cmd.load) begin
			day_q   <= dy_c;
			month_q <= mo_c;
			year_q  <= yr_c;
		end else if (do_step) begin
			if (!neg_q) begin
				if (day_q >= len_cur) begin
					day_q <= 5'd1;
					if (month_q >= 4'd12) begin
						month_q <= 4'd1;
						year_q  <= year_q + 12'd1;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end else begin
					day_q <= day_q + 5'd1;
				end
			end else begin
				if (day_q > 5'd1) begin
					day_q <= day_q - 5'd1;
				end else if (month_q > 4'd1) begin
					month_q <= month_q - 4'd1;
					day_q   <= len_prev;
				end else begin
					month_q <= 4'd12;
					year_q  <= year_q - 12'd1;
					day_q   <= 5'd31;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			ld_day_q   <= load_day;
			ld_month_q <= load_month;
			ld_year_q  <= load_year;
			count_q    <= func ? delta_mag : '0;
			neg_q      <= day_delta[DELTA_BITS-1];
			hit_q      <= 1'b0;
		end else begin
			if (do_step) count_q <= count_q - 1'b1;
			if (cmd.step && !count_zero && at_end) hit_q <= 1'b1;
		end
		if (cmd.sum)  sum_q  <= sum_d;
		if (cmd.wday) wday_q <= rem[2:0];
		if (cmd.out_load) begin
			out_day_q   <= day_q;
			out_month_q <= month_q;
			out_year_q  <= year_q;
			out_wday_q  <= wday_q;
			out_hit_q   <= hit_q;
		end
	end

	assign status.func       = func_q;
	assign status.count_zero = count_zero;
	assign status.at_end     = at_end;

	assign cur_day   = out_day_q;
	assign cur_month = out_month_q;
	assign cur_year  = out_year_q;
	assign week_day  = out_wday_q;
	assign range_hit = out_hit_q;

endmodule

// File: hw/rtl/calendar_date_counter_core.sv
// Top level of the calendar date counter.
// Holds one Gregorian date between 1800-01-01 and 2099-12-31 and returns
// one result per input transfer: the date after the item and its weekday.
// Input channel: in_valid/in_stall with func, load fields and day_delta.
//   func = 0 loads a repaired date, func = 1 steps by signed day_delta.
// Output channel: out_valid/out_stall with cur_day, cur_month, cur_year,
//   week_day (0 = Sunday) and range_hit.
// Sequence: after the transfer the controller runs ST_STEP, ST_SUM, ST_WDAY
//   and ST_OUT. In ST_STEP a load writes the repaired date and an advance
//   steps |day_delta| days, stopping early at a range end. The stepper moves
//   one day per cycle. Flow: one item at a time; in_stall is high from the
//   transfer until the result enters the output register.
// A waiting result does not block the next transfer; only the load of the
//   following result waits while out_stall holds the register.
// Reset: date is 2000-01-01, no result pending, input ready.
module calendar_date_counter_core #(
	parameter int DELTA_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [4:0]                   load_day,
	input  logic [3:0]                   load_month,
	input  logic [11:0]                  load_year,
	input  logic signed [DELTA_BITS-1:0] day_delta,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [4:0]                   cur_day,
	output logic [3:0]                   cur_month,
	output logic [11:0]                  cur_year,
	output logic [2:0]                   week_day,
	output logic                         range_hit
);
	import cdc_pkg::*;

	cmd_t    cmd;
	status_t status;

	cdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	cdc_dpath #(
		.DELTA_BITS (DELTA_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.func       (func),
		.load_day   (load_day),
		.load_month (load_month),
		.load_year  (load_year),
		.day_delta  (day_delta),
		.cur_day    (cur_day),
		.cur_month  (cur_month),
		.cur_year   (cur_year),
		.week_day   (week_day),
		.range_hit  (range_hit)
	);

endmodule

// File: hw/rtl/cdc_checker.sv
// Port-level checks for the calendar date counter, bound to the top level.
module cdc_checker #(
	parameter int DELTA_BITS = 18
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         func,
	input logic [4:0]                   load_day,
	input logic [3:0]                   load_month,
	input logic [11:0]                  load_year,
	input logic signed [DELTA_BITS-1:0] day_delta,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [4:0]                   cur_day,
	input logic [3:0]                   cur_month,
	input logic [11:0]                  cur_year,
	input logic [2:0]                   week_day,
	input logic                         range_hit
);
	import cdc_pkg::*;

	// a stalled input transfer keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(func) && $stable(load_day)
			&& $stable(load_month) && $stable(load_year) && $stable(day_delta))
		else $error("stalled input changed");

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cur_day)
			&& $stable(cur_month) && $stable(cur_year) && $stable(week_day)
			&& $stable(range_hit))
		else $error("stalled result changed");

	// busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input ready right after a transfer");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cur_year >= YEAR_MIN && cur_year <= YEAR_MAX
			&& cur_month >= 4'd1 && cur_month <= 4'd12 && cur_day >= 5'd1)
		else $error("result date out of range");

	a_wday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> week_day <= 3'd6)
		else $error("weekday out of range");

endmodule

bind calendar_date_counter_core cdc_checker #(.DELTA_BITS(DELTA_BITS)) u_cdc_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the calendar date counter against a date predictor.
module tb;
	import cdc_pkg::*;

	localparam int DELTA_W  = 18;
	localparam int N_RANDOM = 1605;
	localparam int N_CALM   = 150;

	// Predicts the date after each accepted transfer and checks results in order.
	class date_scoreboard;
		typedef struct {
			logic [4:0]  day;
			logic [3:0]  month;
			logic [11:0] year;
			logic [2:0]  wday;
			logic        hit;
		} date_result_t;

		date_result_t expected_q[$];
		int unsigned  cal_day;
		int unsigned  cal_month;
		int unsigned  cal_year;
		int           failures;
		int           results_seen;

		function new();
			cal_day      = 1;
			cal_month    = 1;
			cal_year     = 2000;
			failures     = 0;
			results_seen = 0;
		endfunction

		function bit is_leap(int unsigned y);
			return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
		endfunction

		function int unsigned days_in_month(int unsigned m, int unsigned y);
			case (m)
				2: begin
					return is_leap(y) ? 29 : 28;
				end
				4, 6, 9, 11: begin
					return 30;
				end
				default: begin
					return 31;
				end
			endcase
		endfunction

		// Zeller-style count with March as month one
		function int unsigned weekday_calc(int unsigned d, int unsigned m, int unsigned y);
			int unsigned a;
			int unsigned yy;
			int unsigned mm;
			a  = (m <= 2) ? 1 : 0;
			yy = y - a;
			mm = m + 12 * a - 2;
			return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
		endfunction

		function bit step_forward();
			if (cal_year >= YEAR_MAX && cal_month >= 12 && cal_day >= 31) begin
				return 0;
			end
			cal_day++;
			if (cal_day > days_in_month(cal_month, cal_year)) begin
				cal_day = 1;
				cal_month++;
				if (cal_month > 12) begin
					cal_month = 1;
					cal_year++;
				end
			end
			return 1;
		endfunction

		function bit step_backward();
			if (cal_year <= YEAR_MIN && cal_month <= 1 && cal_day <= 1) begin
				return 0;
			end
			if (cal_day > 1) begin
				cal_day--;
			end else begin
				if (cal_month > 1) begin
					cal_month--;
				end else begin
					cal_month = 12;
					cal_year--;
				end
				cal_day = days_in_month(cal_month, cal_year);
			end
			return 1;
		endfunction

		function void note_transfer(logic f, logic [4:0] ld, logic [3:0] lm, logic [11:0] ly,
				logic [DELTA_W-1:0] delta);
			int unsigned  d;
			int unsigned  m;
			int unsigned  y;
			int unsigned  count;
			bit           neg;
			bit           hit;
			bit           moved;
			date_result_t r;
			hit = 0;
			if (!f) begin
				d = ld;
				m = lm;
				y = ly;
				if (y < 100) begin
					y += (y < 50) ? 2000 : 1900;
				end
				if (y < YEAR_MIN) y = YEAR_MIN;
				if (y > YEAR_MAX) y = YEAR_MAX;
				if (m < 1) m = 1;
				if (m > 12) m = 12;
				if (d < 1) d = 1;
				if (d > days_in_month(m, y)) d = days_in_month(m, y);
				cal_day   = d;
				cal_month = m;
				cal_year  = y;
			end else begin
				neg   = delta[DELTA_W-1];
				count = neg ? (32'd1 << DELTA_W) - 32'(delta) : 32'(delta);
				while (count > 0) begin
					moved = neg ? step_backward() : step_forward();
					if (!moved) begin
						hit = 1;
						break;
					end
					count--;
				end
			end
			r.day   = cal_day[4:0];
			r.month = cal_month[3:0];
			r.year  = cal_year[11:0];
			r.wday  = 3'(weekday_calc(cal_day, cal_month, cal_year));
			r.hit   = hit;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [4:0] day, logic [3:0] month, logic [11:0] year,
				logic [2:0] wday, logic hit);
			date_result_t r;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result %0d-%0d-%0d with nothing pending", year, month, day);
				failures++;
				return;
			end
			r = expected_q.pop_front();
			if (day !== r.day) begin
				$error("cur_day mismatch: expected %0d, actual %0d", r.day, day);
				failures++;
			end
			if (month !== r.month) begin
				$error("cur_month mismatch: expected %0d, actual %0d", r.month, month);
				failures++;
			end
			if (year !== r.year) begin
				$error("cur_year mismatch: expected %0d, actual %0d", r.year, year);
				failures++;
			end
			if (wday !== r.wday) begin
				$error("week_day mismatch: expected %0d, actual %0d", r.wday, wday);
				failures++;
			end
			if (hit !== r.hit) begin
				$error("range_hit mismatch: expected %0d, actual %0d", r.hit, hit);
				failures++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      func = 1'b0;
	logic [4:0]                load_day = '0;
	logic [3:0]                load_month = '0;
	logic [11:0]               load_year = '0;
	logic signed [DELTA_W-1:0] day_delta = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [4:0]                cur_day;
	logic [3:0]                cur_month;
	logic [11:0]               cur_year;
	logic [2:0]                week_day;
	logic                      range_hit;

	date_scoreboard sb;
	longint         cycle_cnt = 0;
	longint         cycle_limit = 100000;
	bit             gaps_on = 1'b1;
	bit             calm = 1'b0;

	calendar_date_counter_core #(
		.DELTA_BITS(DELTA_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.load_day  (load_day),
		.load_month(load_month),
		.load_year (load_year),
		.day_delta (day_delta),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cur_day   (cur_day),
		.cur_month (cur_month),
		.cur_year  (cur_year),
		.week_day  (week_day),
		.range_hit (range_hit)
	);

	always #5 clk = ~clk;

	// watchdog; the limit grows with the work each accepted transfer implies
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > cycle_limit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(cur_day, cur_month, cur_year, week_day, range_hit);
		end
	end

	// result side: random stall bursts, one long hold-off so the input backs up
	initial begin
		bit held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sb.results_seen >= 40) begin
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
				out_stall = 1'b0;
				held_off  = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall = 1'b0;
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(20, 60)) @(negedge clk);
				end
			end
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_item(input logic f, input int unsigned ld, input int unsigned lm,
			input int unsigned ly, input int delta);
		int unsigned steps;
		in_valid   = 1'b1;
		func       = f;
		load_day   = ld[4:0];
		load_month = lm[3:0];
		load_year  = ly[11:0];
		day_delta  = delta[DELTA_W-1:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_transfer(func, load_day, load_month, load_year, day_delta);
		steps = (delta < 0) ? -delta : delta;
		if (!f) steps = 0;
		if (steps > 110000) steps = 110000;
		cycle_limit += 4 * (steps + 60);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	// delta is a don't-care on a load transfer
	task automatic load_item(input int unsigned d, input int unsigned m, input int unsigned y);
		send_item(1'b0, d, m, y, int'($urandom_range(0, 262143)) - 131072);
	endtask

	// load fields are don't-cares on an advance transfer
	task automatic advance_item(input int delta);
		send_item(1'b1, $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 4095),
			delta);
	endtask

	initial begin
		int unsigned sel;
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int          delta;
		sb = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset date, clamping, two-digit years, leap days, range ends
		advance_item(0);
		load_item(0, 0, 0);
		load_item(31, 2, 2000);
		advance_item(1);
		advance_item(-1);
		load_item(31, 2, 1900);
		advance_item(1);
		load_item(31, 15, 4095);
		advance_item(1);
		advance_item(-1);
		advance_item(1);
		load_item(31, 12, 49);
		advance_item(1);
		load_item(15, 6, 50);
		load_item(31, 4, 99);
		load_item(1, 1, 100);
		advance_item(-1);
		load_item(31, 12, 1799);
		advance_item(1);
		load_item(31, 12, 1999);
		advance_item(1);
		load_item(15, 6, 2050);
		advance_item(131071);
		load_item(15, 6, 1850);
		advance_item(-131072);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i >= N_RANDOM - N_CALM) begin
				gaps_on = 1'b0;
				calm    = 1'b1;
			end
			if ($urandom_range(0, 99) < 35) begin
				sel = $urandom_range(0, 99);
				m   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
				d   = $urandom_range(0, 31);
				if (sel < 50) begin
					y = $urandom_range(1800, 2099);
				end else if (sel < 65) begin
					y = $urandom_range(0, 99);
				end else if (sel < 80) begin
					y = $urandom_range(0, 4095);
				end else if ($urandom_range(0, 1) == 1) begin
					// close to the upper end so a short advance runs into it
					y = 2099;
					m = 12;
				end else begin
					y = 1800;
					m = 1;
				end
				load_item(d, m, y);
			end else begin
				sel = $urandom_range(0, 999);
				if (sel < 30) begin
					delta = 0;
				end else if (sel < 450) begin
					delta = int'($urandom_range(0, 80)) - 40;
				end else if (sel < 850) begin
					delta = int'($urandom_range(0, 800)) - 400;
				end else if (sel < 997) begin
					delta = int'($urandom_range(0, 6000)) - 3000;
				end else begin
					delta = int'($urandom_range(0, 262143)) - 131072;
				end
				advance_item(delta);
			end
		end
		in_valid = 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
